FILE: rtl/rpfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfe_pkg
// Shared types and codes of the RGBA pixel filter engine.
// ----------------------------------------------------------------------------
package rpfe_pkg;

    localparam logic [2:0] MODE_GRAY      = 3'd0;
    localparam logic [2:0] MODE_THRESHOLD = 3'd1;
    localparam logic [2:0] MODE_OPAQUE    = 3'd2;
    localparam logic [2:0] MODE_INVERT    = 3'd3;
    localparam logic [2:0] MODE_CONVOLVE  = 3'd4;
    localparam logic [2:0] MODE_MASK      = 3'd5;

    localparam logic [2:0] REG_FILTER_MODE  = 3'd0;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd2;
    localparam logic [2:0] REG_THRESHOLD    = 3'd3;
    localparam logic [2:0] REG_KERNEL_UPPER = 3'd4;
    localparam logic [2:0] REG_KERNEL_LOWER = 3'd5;

    localparam int CFG_DATA_W = 48;
    localparam int ACC_W      = 20;  // nine taps of 255 * 255
    localparam int WSUM_W     = 12;  // nine weights of 255
    localparam int NUM_TAPS   = 9;

    typedef struct packed {
        logic [31:0] pixel_in;
        logic [7:0]  mask_byte;
        logic        flush;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        frame_end;
        logic        zero_weight;
    } t_out_item;

    // one window tap as it moves down the cell chain
    typedef struct packed {
        logic [31:0] pixel;
        logic [7:0]  weight;
    } t_tap;

    typedef struct packed {
        logic shift;
        t_tap tap;
    } t_cell_ctl;

endpackage

FILE: rtl/rpfe_tap_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfe_tap_cell
// One window tap: holds a pixel and its weight, hands it on when shifted.
// ----------------------------------------------------------------------------
module rpfe_tap_cell (
    input  logic               i_clk,
    input  rpfe_pkg::t_cell_ctl i_ctl,
    output rpfe_pkg::t_tap     o_tap
);

    rpfe_pkg::t_tap r_tap;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_tap <= i_ctl.tap;
        end
    end

    assign o_tap = r_tap;

endmodule

FILE: rtl/rpfe_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfe_divider
// Four-lane restoring divider, one quotient bit per cycle, 8-bit quotients.
// ----------------------------------------------------------------------------
module rpfe_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rpfe_pkg::ACC_W-1:0]    i_dividend [4],
    input  logic [rpfe_pkg::WSUM_W-1:0]   i_divisor,
    output logic [7:0]                    o_quotient [4],
    output logic                          o_done
);

    logic [rpfe_pkg::ACC_W-1:0]  r_rem [4];
    logic [rpfe_pkg::ACC_W-1:0]  n_rem [4];
    logic [7:0]                  r_quo [4];
    logic [7:0]                  n_quo [4];
    logic [rpfe_pkg::WSUM_W-1:0] r_div;
    logic [2:0]                  r_step;
    logic                        r_busy;
    logic                        r_done;
    logic [rpfe_pkg::ACC_W-1:0]  shifted;

    always_comb begin
        shifted = rpfe_pkg::ACC_W'(r_div) << r_step;
        for (int ch = 0; ch < 4; ch++) begin
            if (r_rem[ch] >= shifted) begin
                n_rem[ch] = r_rem[ch] - shifted;
                n_quo[ch] = {r_quo[ch][6:0], 1'b1};
            end else begin
                n_rem[ch] = r_rem[ch];
                n_quo[ch] = {r_quo[ch][6:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 3'd7;
            end else if (r_busy) begin
                r_step <= r_step - 3'd1;
                if (r_step == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            for (int ch = 0; ch < 4; ch++) begin
                r_rem[ch] <= i_dividend[ch];
                r_quo[ch] <= '0;
            end
        end else if (r_busy) begin
            for (int ch = 0; ch < 4; ch++) begin
                r_rem[ch] <= n_rem[ch];
                r_quo[ch] <= n_quo[ch];
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

FILE: rtl/rgba_pixel_filter_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_pixel_filter_engine_top
// RGBA point filters and 3x3 weighted-average convolution over raster input.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A point-mode pixel passes through the
// result register and then the output register. A convolve item that releases
// an output does nine line-store reads filling a chain of nine tap cells, nine
// multiply-accumulate steps as the chain drains, and eight steps of the shared
// divider; a convolve item that releases nothing returns from check to idle.
// The single-port line-store read and the bit-serial divider set the length
// of a convolve item. The output register lets the next transaction enter
// while a result waits. The line store needs no clearing pass after reset.
module rgba_pixel_filter_engine_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rpfe_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output rpfe_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_idx,
    input  logic [rpfe_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int RW        = $clog2(MAX_HEIGHT + 1);
    localparam int MEM_DEPTH = 4 * (2 ** CW);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_MAC   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    // configuration
    logic [2:0]  r_mode;
    logic [10:0] r_width;
    logic [10:0] r_height;
    logic [7:0]  r_level;
    logic [47:0] r_kup;
    logic [23:0] r_klo;

    t_state r_state;
    logic [CW-1:0] r_in_col;
    logic [RW-1:0] r_in_row;
    logic [CW-1:0] r_out_col;
    logic [RW-1:0] r_out_row;

    logic [31:0] r_mem [MEM_DEPTH];
    logic [31:0] r_rd;
    logic [7:0]  r_pw;
    logic        r_push;

    logic [3:0]  r_k;
    logic [1:0]  r_fr;
    logic [1:0]  r_fc;

    logic [rpfe_pkg::ACC_W-1:0]  r_acc [4];
    logic [rpfe_pkg::WSUM_W-1:0] r_wsum;
    logic [7:0]                  quo [4];
    logic                        div_done;
    logic                        div_start;
    logic                        r_div_go;

    rpfe_pkg::t_out_item r_res;
    logic                r_is_conv;
    logic                r_out_valid;
    rpfe_pkg::t_out_item r_out;

    rpfe_pkg::t_tap      tap_out [rpfe_pkg::NUM_TAPS];
    rpfe_pkg::t_cell_ctl cell_ctl [rpfe_pkg::NUM_TAPS];

    // effective frame size
    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff;

    always_comb begin
        if (r_width == 11'd0) begin
            w_eff = WW'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        if (r_height == 11'd0) begin
            h_eff = RW'(1);
        end else if (int'(r_height) > MAX_HEIGHT) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(r_height);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= rpfe_pkg::MODE_GRAY;
            r_width  <= 11'd1;
            r_height <= 11'd1;
            r_level  <= 8'd1;
            r_kup    <= 48'd2216236745217;
            r_klo    <= 24'd66049;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rpfe_pkg::REG_FILTER_MODE:  r_mode   <= i_cfg_data[2:0];
                rpfe_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[10:0];
                rpfe_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data[10:0];
                rpfe_pkg::REG_THRESHOLD:    r_level  <= i_cfg_data[7:0];
                rpfe_pkg::REG_KERNEL_UPPER: r_kup    <= i_cfg_data[47:0];
                rpfe_pkg::REG_KERNEL_LOWER: r_klo    <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // input side: position advance and point filter
    logic          accept;
    logic          in_complete;
    logic [WW:0]   in_col_inc;
    logic          in_wrap;
    logic [CW-1:0] adv_col;
    logic [RW:0]   adv_row;
    logic          adv_last;
    logic [9:0]    rgb_sum;
    logic [7:0]    mean;
    logic [31:0]   point_px;
    logic [31:0]   px_in;

    assign accept = i_in_valid && !o_in_stall;
    assign px_in  = i_in_item.pixel_in;

    always_comb begin
        in_complete = (r_in_row >= h_eff);
        in_col_inc  = (WW + 1)'(r_in_col) + (WW + 1)'(1);
        in_wrap     = (in_col_inc >= (WW + 1)'(w_eff));
        adv_col     = in_wrap ? '0 : CW'(in_col_inc);
        adv_row     = (RW + 1)'(r_in_row) + (RW + 1)'(in_wrap);
        adv_last    = (adv_row >= (RW + 1)'(h_eff));

        rgb_sum  = 10'(px_in[7:0]) + 10'(px_in[15:8]) + 10'(px_in[23:16]);
        mean     = 8'((21'(rgb_sum) * 21'd683) >> 11);  // exact divide by 3
        case (r_mode)
            rpfe_pkg::MODE_GRAY:      point_px = {px_in[31:24], mean, mean, mean};
            rpfe_pkg::MODE_THRESHOLD:
                point_px = (mean > r_level) ? {px_in[31:24], 24'hFFFFFF}
                                            : {px_in[31:24], 24'h000000};
            rpfe_pkg::MODE_OPAQUE:    point_px = {8'hFF, px_in[23:0]};
            rpfe_pkg::MODE_INVERT:    point_px = px_in ^ 32'h00FFFFFF;
            rpfe_pkg::MODE_MASK:      point_px = {i_in_item.mask_byte, px_in[23:0]};
            default:                  point_px = px_in;
        endcase
    end

    // output readiness test for convolve
    logic [WW:0] out_col_inc;
    logic [WW:0] nx;
    logic [RW:0] need_row;
    logic        can_emit;
    logic        out_wrap;
    logic [RW:0] out_adv_row;

    always_comb begin
        out_col_inc = (WW + 1)'(r_out_col) + (WW + 1)'(1);
        nx          = (out_col_inc < (WW + 1)'(w_eff)) ? out_col_inc
                                                       : (WW + 1)'(w_eff) - (WW + 1)'(1);
        need_row    = (RW + 1)'(r_out_row) + (RW + 1)'(1);
        can_emit    = in_complete
                   || ((RW + 1)'(r_in_row) > need_row)
                   || (((RW + 1)'(r_in_row) == need_row) && ((WW + 1)'(r_in_col) > nx));
        out_wrap    = (out_col_inc >= (WW + 1)'(w_eff));
        out_adv_row = (RW + 1)'(r_out_row) + (RW + 1)'(out_wrap);
    end

    // tap fetch addressing
    logic [WW:0]   xs;
    logic [RW:0]   ys;
    logic          tap_in;
    logic [WW:0]   x_m1;
    logic [RW:0]   y_m1;
    logic [CW+1:0] rd_addr;
    logic [7:0]    tap_w;
    logic [71:0]   kernel_all;

    always_comb begin
        xs         = (WW + 1)'(r_out_col) + (WW + 1)'(r_fc);
        ys         = (RW + 1)'(r_out_row) + (RW + 1)'(r_fr);
        x_m1       = xs - (WW + 1)'(1);
        y_m1       = ys - (RW + 1)'(1);
        tap_in     = (xs != '0) && (xs <= (WW + 1)'(w_eff))
                  && (ys != '0) && (ys <= (RW + 1)'(h_eff));
        rd_addr    = {y_m1[1:0], x_m1[CW-1:0]};
        kernel_all = {r_klo, r_kup};
        tap_w      = kernel_all[r_k*8 +: 8];
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (accept && !i_in_item.flush && !in_complete
            && ((WW + 1)'(r_in_col) < (WW + 1)'(w_eff))) begin
            r_mem[{r_in_row[1:0], r_in_col}] <= px_in;
        end
        r_rd <= r_mem[rd_addr];
    end

    // tap cell chain
    genvar g;
    generate
        for (g = 0; g < rpfe_pkg::NUM_TAPS; g++) begin : g_cell
            if (g == 0) begin : g_head
                // zero the pixel of an unused tap so stale store data never reaches the sum
                assign cell_ctl[g].shift       = r_push || (r_state == S_MAC);
                assign cell_ctl[g].tap.pixel  = (r_push && (r_pw != 8'd0)) ? r_rd : '0;
                assign cell_ctl[g].tap.weight = r_push ? r_pw : '0;
            end else begin : g_body
                assign cell_ctl[g].shift = r_push || (r_state == S_MAC);
                assign cell_ctl[g].tap   = tap_out[g-1];
            end
            rpfe_tap_cell u_cell (
                .i_clk (i_clk),
                .i_ctl (cell_ctl[g]),
                .o_tap (tap_out[g])
            );
        end
    endgenerate

    // start the divider once the last tap has been accumulated
    assign div_start = r_div_go;

    rpfe_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_wsum),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    logic emit_load;
    assign emit_load = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_push      <= 1'b0;
            r_div_go    <= 1'b0;
            r_k         <= '0;
            r_fr        <= '0;
            r_fc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_push   <= (r_state == S_FETCH);
            r_div_go <= (r_state == S_MAC) && (r_k == 4'd8);
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (r_mode != rpfe_pkg::MODE_CONVOLVE) begin
                            if (!i_in_item.flush) begin
                                if (adv_last) begin
                                    r_in_col  <= '0;
                                    r_in_row  <= '0;
                                    r_out_col <= '0;
                                    r_out_row <= '0;
                                end else begin
                                    r_in_col  <= adv_col;
                                    r_in_row  <= RW'(adv_row);
                                    r_out_col <= adv_col;
                                    r_out_row <= RW'(adv_row);
                                end
                                r_is_conv <= 1'b0;
                                r_state   <= S_EMIT;
                            end
                        end else begin
                            if (!i_in_item.flush && !in_complete) begin
                                r_in_col <= adv_col;
                                r_in_row <= RW'(adv_row);
                            end
                            r_is_conv <= 1'b1;
                            r_state   <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (can_emit) begin
                        r_k     <= '0;
                        r_fr    <= '0;
                        r_fc    <= '0;
                        r_state <= S_FETCH;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_FETCH: begin
                    if (r_fc == 2'd2) begin
                        r_fc <= '0;
                        r_fr <= r_fr + 2'd1;
                    end else begin
                        r_fc <= r_fc + 2'd1;
                    end
                    if (r_k == 4'd8) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_LOAD: begin
                    r_k     <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (r_k == 4'd8) begin
                        r_state <= S_DIV;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_is_conv) begin
                            if (out_adv_row >= (RW + 1)'(h_eff)) begin
                                r_in_col  <= '0;
                                r_in_row  <= '0;
                                r_out_col <= '0;
                                r_out_row <= '0;
                            end else begin
                                r_out_col <= out_wrap ? '0 : CW'(out_col_inc);
                                r_out_row <= RW'(out_adv_row);
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH) begin
            r_pw <= tap_in ? tap_w : 8'd0;
        end
        if (r_state == S_CHECK) begin
            r_wsum <= '0;
            for (int ch = 0; ch < 4; ch++) begin
                r_acc[ch] <= '0;
            end
        end else if (r_state == S_MAC) begin
            r_wsum <= r_wsum + rpfe_pkg::WSUM_W'(tap_out[rpfe_pkg::NUM_TAPS-1].weight);
            for (int ch = 0; ch < 4; ch++) begin
                r_acc[ch] <= r_acc[ch] + rpfe_pkg::ACC_W'(
                    16'(tap_out[rpfe_pkg::NUM_TAPS-1].weight)
                    * 16'(tap_out[rpfe_pkg::NUM_TAPS-1].pixel[ch*8 +: 8]));
            end
        end
        if ((r_state == S_IDLE) && accept) begin
            r_res.pixel_out   <= point_px;
            r_res.frame_end   <= adv_last;
            r_res.zero_weight <= 1'b0;
        end else if ((r_state == S_DIV) && div_done) begin
            if (r_wsum == '0) begin
                r_res.pixel_out   <= '0;
                r_res.zero_weight <= 1'b1;
            end else begin
                r_res.pixel_out   <= {quo[3], quo[2], quo[1], quo[0]};
                r_res.zero_weight <= 1'b0;
            end
        end
        if (emit_load) begin
            r_out.pixel_out   <= r_res.pixel_out;
            r_out.zero_weight <= r_res.zero_weight;
            r_out.frame_end   <= r_is_conv ? (out_adv_row >= (RW + 1)'(h_eff))
                                           : r_res.frame_end;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // checks
    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_in_row) <= MAX_HEIGHT) && (int'(r_out_row) <= MAX_HEIGHT))
        else $error("row position out of range");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && r_is_conv && (out_adv_row >= (RW + 1)'(h_eff)))
        |=> (r_in_row == '0) && (r_out_row == '0) && (r_out_col == '0))
        else $error("positions not cleared at end of frame");

    a_push_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_push |-> ($past(r_state) == S_FETCH))
        else $error("tap push without a fetch");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGBA pixel filter engine: a directed table of
// single-pixel frames across every mode, then random frames of random size,
// kernel and level, with bursty input, patterned output stall and long output
// hold-offs. Each output is checked against its table entry or an in-bench pixel predictor.
// ----------------------------------------------------------------------------
module tb;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    rpfe_pkg::t_in_item              in_item = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    rpfe_pkg::t_out_item             out_item;
    logic                            cfg_we = 1'b0;
    logic [2:0]                      cfg_idx = rpfe_pkg::REG_FILTER_MODE;
    logic [rpfe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    always #1 i_clk = ~i_clk;

    rgba_pixel_filter_engine_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // predictor copy of configuration and state
    logic [2:0]  cur_mode = rpfe_pkg::MODE_GRAY;
    logic [10:0] cur_width = 11'd1;
    logic [10:0] cur_height = 11'd1;
    logic [7:0]  cur_level = 8'd1;
    logic [47:0] kern_up = 48'h0204_0201_0201;
    logic [23:0] kern_lo = 24'h01_0201;
    logic [31:0] pix_rows [4][1024];
    int          in_col = 0, in_row = 0, out_col = 0, out_row = 0;

    rpfe_pkg::t_out_item pixel_q [$];
    int          err_cnt = 0;
    int          pix_sent = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    bit          hold_req = 0;

    function automatic int eff_w();
        return (cur_width < 1) ? 1 : (cur_width > 1024) ? 1024 : int'(cur_width);
    endfunction

    function automatic int eff_h();
        return (cur_height < 1) ? 1 : (cur_height > 1024) ? 1024 : int'(cur_height);
    endfunction

    function automatic void step_pos(ref int c, ref int r, input int w);
        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
    endfunction

    function automatic logic [31:0] point_pixel(logic [31:0] p, logic [7:0] m);
        int mean;
        mean = (int'(p[7:0]) + int'(p[15:8]) + int'(p[23:16])) / 3;
        case (cur_mode)
            rpfe_pkg::MODE_GRAY:      return {p[31:24], mean[7:0], mean[7:0], mean[7:0]};
            rpfe_pkg::MODE_THRESHOLD: return (mean > cur_level) ? {p[31:24], 24'hFFFFFF}
                                                                : {p[31:24], 24'h0};
            rpfe_pkg::MODE_OPAQUE:    return {8'hFF, p[23:0]};
            rpfe_pkg::MODE_INVERT:    return p ^ 32'h00FF_FFFF;
            rpfe_pkg::MODE_MASK:      return {m, p[23:0]};
            default:                  return p;
        endcase
    endfunction

    function automatic logic [31:0] conv_pixel(int ox, int oy, int w, int h, output bit zero);
        int acc [4];
        int wsum, x, y, q;
        logic [7:0]  wt;
        logic [31:0] p, res;
        acc = '{0, 0, 0, 0};
        wsum = 0;
        res = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                x = ox + c - 1;
                y = oy + r - 1;
                if (x >= 0 && x < w && y >= 0 && y < h) begin
                    wt = (r < 2) ? kern_up[(r * 3 + c) * 8 +: 8] : kern_lo[c * 8 +: 8];
                    p = pix_rows[y % 4][x];
                    for (int k = 0; k < 4; k++)
                        acc[k] += int'(wt) * int'(p[k * 8 +: 8]);
                    wsum += int'(wt);
                end
            end
        end
        zero = (wsum == 0);
        if (zero)
            return '0;
        for (int k = 0; k < 4; k++) begin
            q = acc[k] / wsum;
            if (q > 255)
                q = 255;
            res[k * 8 +: 8] = q[7:0];
        end
        return res;
    endfunction

    function automatic bit filter_predict(input rpfe_pkg::t_in_item it,
                                          output rpfe_pkg::t_out_item r);
        int w, h, nx;
        longint got, need;
        bit done, z;
        w = eff_w();
        h = eff_h();
        r = '0;
        done = in_row >= h;
        if (!it.flush && !done && in_col < w)
            pix_rows[in_row % 4][in_col] = it.pixel_in;
        if (cur_mode != rpfe_pkg::MODE_CONVOLVE) begin
            if (it.flush)
                return 0;
            step_pos(in_col, in_row, w);
            out_col = in_col;
            out_row = in_row;
            r.pixel_out = point_pixel(it.pixel_in, it.mask_byte);
            r.frame_end = in_row >= h;
            if (r.frame_end) begin
                in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            end
            return 1;
        end
        if (!it.flush && !done)
            step_pos(in_col, in_row, w);
        done = in_row >= h;
        got = longint'(in_row) * w + in_col;
        nx = (out_col + 1 < w) ? out_col + 1 : w - 1;
        need = longint'(out_row + 1) * w + nx + 1;
        if (!done && got < need)
            return 0;
        r.pixel_out = conv_pixel(out_col, out_row, w, h, z);
        r.zero_weight = z;
        step_pos(out_col, out_row, w);
        r.frame_end = out_row >= h;
        if (r.frame_end) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
        return 1;
    endfunction

    // output checker
    always @(posedge i_clk) begin
        rpfe_pkg::t_out_item want;
        if (out_valid && !out_stall) begin
            if (pixel_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected output %h", out_item);
            end else begin
                want = pixel_q.pop_front();
                if (want.pixel_out !== out_item.pixel_out
                        || want.frame_end !== out_item.frame_end
                        || want.zero_weight !== out_item.zero_weight) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: pixel %h/%h frame_end %b/%b zero %b/%b (exp/act)",
                                 want.pixel_out, out_item.pixel_out, want.frame_end,
                                 out_item.frame_end, want.zero_weight, out_item.zero_weight);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 4000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: stall pattern in phases, plus one long hold-off on request
    initial begin
        int phase_len, pct, hold;
        forever begin
            phase_len = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
                0: pct = 0;
                1: pct = 25;
                2: pct = 50;
                default: pct = 90;
            endcase
            repeat (phase_len) begin
                @(posedge i_clk);
                if (hold_req) begin
                    hold_req = 0;
                    out_stall <= 1'b1;
                    for (hold = 0; hold < 400; hold++)
                        @(posedge i_clk);
                end
                out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    task automatic send_item(input rpfe_pkg::t_in_item it, input bit typed,
                             input rpfe_pkg::t_out_item want);
        int gap;
        rpfe_pkg::t_out_item got;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        burst_left--;
        if (filter_predict(it, got))
            pixel_q.insert(pixel_q.size(), typed ? want : got);
        pix_sent++;
    endtask

    // drain expectations; allow a silent convolve item to finish
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [47:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            rpfe_pkg::REG_FILTER_MODE:  cur_mode = data[2:0];
            rpfe_pkg::REG_IMAGE_WIDTH:  cur_width = data[10:0];
            rpfe_pkg::REG_IMAGE_HEIGHT: cur_height = data[10:0];
            rpfe_pkg::REG_THRESHOLD:    cur_level = data[7:0];
            rpfe_pkg::REG_KERNEL_UPPER: kern_up = data[47:0];
            default:                    kern_lo = data[23:0];
        endcase
    endtask

    function automatic logic [7:0] rand_weight(int style);
        case (style)
            0: return 8'h00;
            1: return 8'hFF;
            default: return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        endcase
    endfunction

    task automatic run_frame(input logic [2:0] mode, input int w, input int h);
        int npix, style;
        rpfe_pkg::t_in_item it;
        logic [47:0] ku;
        logic [23:0] kl;
        style = $urandom_range(0, 9);
        for (int b = 0; b < 6; b++)
            ku[b * 8 +: 8] = rand_weight(style);
        for (int b = 0; b < 3; b++)
            kl[b * 8 +: 8] = rand_weight(style);
        quiesce();
        cfg_write(rpfe_pkg::REG_FILTER_MODE, 48'(mode));
        cfg_write(rpfe_pkg::REG_IMAGE_WIDTH, 48'(w));
        cfg_write(rpfe_pkg::REG_IMAGE_HEIGHT, 48'(h));
        case ($urandom_range(0, 3))
            0: cfg_write(rpfe_pkg::REG_THRESHOLD, 48'h0);
            1: cfg_write(rpfe_pkg::REG_THRESHOLD, 48'hFF);
            default: cfg_write(rpfe_pkg::REG_THRESHOLD, 48'($urandom_range(0, 255)));
        endcase
        cfg_write(rpfe_pkg::REG_KERNEL_UPPER, ku);
        cfg_write(rpfe_pkg::REG_KERNEL_LOWER, 48'(kl));
        if (pix_sent > 1250 && pix_sent < 1400)
            hold_req = 1;
        npix = eff_w() * eff_h();
        for (int i = 0; i < npix; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                it = '{pixel_in: $urandom, mask_byte: 8'($urandom), flush: 1'b1};
                send_item(it, 0, '0);
            end
            it.pixel_in  = ($urandom_range(0, 7) == 0) ? {32{$urandom_range(0, 1) == 1}}
                                                       : $urandom;
            it.mask_byte = 8'($urandom);
            it.flush     = 1'b0;
            send_item(it, 0, '0);
        end
        // drain convolve output; stray pixels past the frame act as flushes
        while (in_row != 0 || in_col != 0 || out_row != 0 || out_col != 0) begin
            it = '{pixel_in: $urandom, mask_byte: 8'($urandom),
                   flush: ($urandom_range(0, 2) != 0)};
            send_item(it, 0, '0);
        end
    endtask

    typedef struct {
        logic [2:0]          mode;
        rpfe_pkg::t_in_item  it;
        bit                  typed;
        rpfe_pkg::t_out_item want;
    } t_row;

    t_row dir_tab [16] = '{
        '{rpfe_pkg::MODE_GRAY,      '{32'h0000_0000, 8'h00, 1'b0}, 1,
          '{32'h0000_0000, 1'b1, 1'b0}},
        '{rpfe_pkg::MODE_GRAY,      '{32'hFFFF_FFFF, 8'hFF, 1'b0}, 1,
          '{32'hFFFF_FFFF, 1'b1, 1'b0}},
        '{rpfe_pkg::MODE_GRAY,      '{32'h1203_0201, 8'h00, 1'b0}, 1,
          '{32'h1202_0202, 1'b1, 1'b0}},
        '{rpfe_pkg::MODE_GRAY,      '{32'h89AB_CDEF, 8'h55, 1'b1}, 0,
          '{32'h0, 1'b0, 1'b0}},
        '{rpfe_pkg::MODE_THRESHOLD, '{32'h0000_0000, 8'h00, 1'b0}, 1,
          '{32'h0000_0000, 1'b1, 1'b0}},
        '{rpfe_pkg::MODE_THRESHOLD, '{32'hAB02_0202, 8'h00, 1'b0}, 1,
          '{32'hABFF_FFFF, 1'b1, 1'b0}},
        '{rpfe_pkg::MODE_THRESHOLD, '{32'h5501_0101, 8'h00, 1'b0}, 1,
          '{32'h5500_0000, 1'b1, 1'b0}},
        '{rpfe_pkg::MODE_OPAQUE,    '{32'h0012_3456, 8'h00, 1'b0}, 1,
          '{32'hFF12_3456, 1'b1, 1'b0}},
        '{rpfe_pkg::MODE_INVERT,    '{32'h8012_3456, 8'h00, 1'b0}, 1,
          '{32'h80ED_CBA9, 1'b1, 1'b0}},
        '{rpfe_pkg::MODE_MASK,      '{32'h1122_3344, 8'hAB, 1'b0}, 1,
          '{32'hAB22_3344, 1'b1, 1'b0}},
        '{3'd6,                     '{32'hDEAD_BEEF, 8'h12, 1'b0}, 1,
          '{32'hDEAD_BEEF, 1'b1, 1'b0}},
        '{3'd7,                     '{32'h0102_0304, 8'h34, 1'b0}, 1,
          '{32'h0102_0304, 1'b1, 1'b0}},
        '{rpfe_pkg::MODE_CONVOLVE,  '{32'hCAFE_F00D, 8'h00, 1'b0}, 1,
          '{32'hCAFE_F00D, 1'b1, 1'b0}},
        '{rpfe_pkg::MODE_CONVOLVE,  '{32'h1234_5678, 8'h00, 1'b1}, 0,
          '{32'h0, 1'b0, 1'b0}},
        '{rpfe_pkg::MODE_CONVOLVE,  '{32'hFFFF_FFFF, 8'h00, 1'b0}, 1,
          '{32'hFFFF_FFFF, 1'b1, 1'b0}},
        '{rpfe_pkg::MODE_MASK,      '{32'hFFFF_FFFF, 8'h00, 1'b0}, 1,
          '{32'h00FF_FFFF, 1'b1, 1'b0}}
    };

    initial begin
        int w, h, m;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 1024; c++)
                pix_rows[r][c] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-pixel frames at reset size
        foreach (dir_tab[i]) begin
            if (dir_tab[i].mode != cur_mode) begin
                quiesce();
                cfg_write(rpfe_pkg::REG_FILTER_MODE, 48'(dir_tab[i].mode));
            end
            send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
        end

        // size extremes: clamped full width with zero height, zero width, then a 3x2 frame
        run_frame(rpfe_pkg::MODE_CONVOLVE, 2047, 0);
        run_frame(rpfe_pkg::MODE_CONVOLVE, 0, 3);
        run_frame(rpfe_pkg::MODE_CONVOLVE, 3, 2047 > 0 ? 2 : 2);

        while (pix_sent < 1650) begin
            m = $urandom_range(0, 9);
            w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
            h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
            run_frame((m < 5) ? rpfe_pkg::MODE_CONVOLVE : 3'($urandom_range(0, 7)), w, h);
        end

        quiesce();
        repeat (60) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

FILE: rgba_pixel_filter_engine_top.f
rtl/rpfe_pkg.sv
rtl/rpfe_tap_cell.sv
rtl/rpfe_divider.sv
rtl/rgba_pixel_filter_engine_top.sv
tb/tb.sv
